FILE: design/wbc_pkg.sv
// ----------------------------------------------------------------------------
// wbc_pkg
// Shared types, operand select codes and saturation helpers for the
// white-boundary collision-probability correction block.
// ----------------------------------------------------------------------------
package wbc_pkg;

	localparam int VAL_W  = 48;           // signed fixed-point value width
	localparam int MAG_W  = 47;           // unsigned cell data width
	localparam int SUM_W  = 56;           // exact sum before saturation
	localparam int DIVA_W = 51;           // signed dividend width (holds 4*V)
	localparam int HALF_W = 24;           // multiplier slice width
	localparam int SA_W   = 47;
	localparam int ALB_W  = 25;
	localparam int CNT_W  = 4;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	localparam logic [VAL_W-1:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN = 48'h8000_0000_0000;
	localparam logic signed [SUM_W-1:0] SUM_MAX = 56'sh00_7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 56'shFF_8000_0000_0000;

	// register indexes on the configuration port
	localparam logic [1:0] REG_SURFACE = 2'd0;
	localparam logic [1:0] REG_ALBEDO  = 2'd1;
	localparam logic [1:0] REG_COUNT   = 2'd2;

	// multiplier operand selects
	localparam logic [2:0] MS_PSI  = 3'd0;   // ratio * escape(i)
	localparam logic [2:0] MS_PSIG = 3'd1;   // psi(j) * sigma(j)
	localparam logic [2:0] MS_ALB  = 3'd2;   // Pss * albedo
	localparam logic [2:0] MS_T    = 3'd3;   // escape(i) * psi(j)
	localparam logic [2:0] MS_COEF = 3'd4;   // previous product * factor

	// divider operand selects
	localparam logic [1:0] DS_RAT = 2'd0;    // 4*V(i) / surface
	localparam logic [1:0] DS_FAC = 2'd1;    // albedo / (1 - Pss*albedo)
	localparam logic [1:0] DS_RED = 2'd2;    // P(i,j) / sigma(j)

	typedef struct packed {
		logic       gerr_clr;
		logic       gerr_upd;
		logic       acc_clr;
		logic       acc_add_mat;
		logic       acc_add_mul;
		logic       esc_wr;
		logic       psi_wr;
		logic       fac_wr;
		logic       mul_start;
		logic [2:0] mul_sel;
		logic       div_start;
		logic [1:0] div_sel;
		logic       emit;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} sts_t;

	// sign a magnitude and clamp it to the value range
	function automatic logic [VAL_W-1:0] sat_signed(input logic neg, input logic [127:0] m);
		logic big;
		logic over;
		big  = |m[127:VAL_W-1];
		over = (|m[127:VAL_W]) || (m[VAL_W-1] && (|m[VAL_W-2:0]));
		if (!neg) begin
			return big ? VAL_MAX : {1'b0, m[VAL_W-2:0]};
		end
		return over ? VAL_MIN : (~m[VAL_W-1:0] + 1'b1);
	endfunction

	// clamp an exact sum to the value range
	function automatic logic [VAL_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
		if (v > SUM_MAX) begin
			return VAL_MAX;
		end
		if (v < SUM_MIN) begin
			return VAL_MIN;
		end
		return v[VAL_W-1:0];
	endfunction

endpackage

FILE: design/wbc_mul.sv
// ----------------------------------------------------------------------------
// wbc_mul
// Sequential signed fixed-point multiplier: four 24x24 partial products,
// then truncation by the fraction width and saturation.
// ----------------------------------------------------------------------------
module wbc_mul #(
	parameter int FRAC_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [wbc_pkg::VAL_W-1:0] a,
	input  logic [wbc_pkg::VAL_W-1:0] b,
	output logic [wbc_pkg::VAL_W-1:0] res,
	output logic                      done
);
	import wbc_pkg::*;

	localparam int PROD_W = 2 * VAL_W;

	logic                busy_q;
	logic [2:0]          cnt_q;
	logic                done_q;
	logic                neg_q;
	logic [VAL_W-1:0]    ma_q, mb_q;
	logic [PROD_W-1:0]   acc_q;
	logic [VAL_W-1:0]    res_q;
	logic [HALF_W-1:0]   ah, bh;
	logic [2*HALF_W-1:0] pp;
	logic [PROD_W-1:0]   pp_sh;

	always_comb begin
		ah    = cnt_q[1] ? ma_q[VAL_W-1:HALF_W] : ma_q[HALF_W-1:0];
		bh    = cnt_q[0] ? mb_q[VAL_W-1:HALF_W] : mb_q[HALF_W-1:0];
		pp    = ah * bh;
		pp_sh = PROD_W'(pp) << (HALF_W * (32'(cnt_q[1]) + 32'(cnt_q[0])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[VAL_W-1] ^ b[VAL_W-1];
			ma_q  <= a[VAL_W-1] ? (~a + 1'b1) : a;
			mb_q  <= b[VAL_W-1] ? (~b + 1'b1) : b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == 3'd4) begin
				res_q <= sat_signed(neg_q, 128'(acc_q >> FRAC_BITS));
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

FILE: design/wbc_div.sv
// ----------------------------------------------------------------------------
// wbc_div
// Restoring fixed-point divider, one quotient bit per cycle. A zero divisor
// saturates the quotient by the dividend's sign and raises the flag.
// ----------------------------------------------------------------------------
module wbc_div #(
	parameter int FRAC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wbc_pkg::DIVA_W-1:0] a,
	input  logic [wbc_pkg::VAL_W-1:0]  b,
	output logic [wbc_pkg::VAL_W-1:0]  res,
	output logic                       dz,
	output logic                       done
);
	import wbc_pkg::*;

	localparam int NW    = DIVA_W + FRAC_BITS;
	localparam int CNT_B = $clog2(NW + 1);

	logic              busy_q;
	logic [CNT_B-1:0]  cnt_q;
	logic              done_q;
	logic              neg_q;
	logic              dz_q;
	logic [VAL_W-1:0]  mb_q;
	logic [VAL_W-1:0]  rem_q;
	logic [NW-1:0]     qn_q;
	logic [VAL_W-1:0]  res_q;
	logic [DIVA_W-1:0] ma;
	logic [VAL_W:0]    rsh;
	logic              ge;

	always_comb begin
		ma  = a[DIVA_W-1] ? (~a + 1'b1) : a;
		rsh = {rem_q, qn_q[NW-1]};
		ge  = rsh >= {1'b0, mb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= (b != '0);
				done_q <= (b == '0);
				cnt_q  <= CNT_B'(NW);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= a[DIVA_W-1] ^ b[VAL_W-1];
			mb_q  <= b[VAL_W-1] ? (~b + 1'b1) : b;
			rem_q <= '0;
			qn_q  <= NW'(ma) << FRAC_BITS;
			dz_q  <= (b == '0);
			if (b == '0) begin
				res_q <= a[DIVA_W-1] ? VAL_MIN : VAL_MAX;
			end
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				res_q <= sat_signed(neg_q, 128'(qn_q));
			end else begin
				rem_q <= ge ? VAL_W'(rsh - {1'b0, mb_q}) : rsh[VAL_W-1:0];
				qn_q  <= {qn_q[NW-2:0], ge};
			end
		end
	end

	assign res  = res_q;
	assign dz   = dz_q;
	assign done = done_q;

endmodule

FILE: design/wbc_dp.sv
// ----------------------------------------------------------------------------
// wbc_dp
// Datapath: cell and matrix stores, sums, operand selection for the shared
// multiplier and divider, error flag and the result registers.
// ----------------------------------------------------------------------------
module wbc_dp #(
	parameter int MAX_CELLS = 8,
	parameter int FRAC_BITS = 24,
	parameter int IW        = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wbc_pkg::cmd_t             cmd,
	output wbc_pkg::sts_t             sts,
	input  logic [IW-1:0]             idx_a,
	input  logic [IW-1:0]             idx_b,
	input  logic                      load_en,
	input  logic                      operation,
	input  logic [2:0]                row,
	input  logic [2:0]                col,
	input  logic [wbc_pkg::VAL_W-1:0] prob_in,
	input  logic [wbc_pkg::MAG_W-1:0] cross_section,
	input  logic [wbc_pkg::MAG_W-1:0] cell_volume,
	input  logic [wbc_pkg::SA_W-1:0]  surface_area,
	input  logic [wbc_pkg::ALB_W-1:0] albedo,
	output logic                      result_valid,
	output logic [2:0]                out_row,
	output logic [2:0]                out_col,
	output logic [wbc_pkg::VAL_W-1:0] prob_out,
	output logic                      status,
	output logic                      last_out
);
	import wbc_pkg::*;

	localparam int MD = 1 << (2 * IW);
	localparam logic signed [SUM_W-1:0] ONE = 56'sd1 <<< FRAC_BITS;

	logic [MAG_W-1:0] sig_q [MAX_CELLS];
	logic [MAG_W-1:0] vol_q [MAX_CELLS];
	logic [VAL_W-1:0] esc_q [MAX_CELLS];
	logic [VAL_W-1:0] psi_q [MAX_CELLS];
	logic [VAL_W-1:0] mat_mem [MD];
	logic [VAL_W-1:0] mat_q;

	logic signed [SUM_W-1:0] acc_q;
	logic [VAL_W-1:0] fac_q;
	logic             gerr_q;

	logic [IW+2:0] row_x, col_x, ia_x, ib_x;
	logic          row_ok, col_ok;

	logic [VAL_W-1:0]  mul_a, mul_b, mul_res;
	logic [DIVA_W-1:0] div_a;
	logic [VAL_W-1:0]  div_b, div_res;
	logic              mul_done, div_done, div_dz;

	logic              valid_q;
	logic [2:0]        orow_q, ocol_q;
	logic [VAL_W-1:0]  oval_q;
	logic              ostat_q, olast_q;

	assign row_x  = {{IW{1'b0}}, row};
	assign col_x  = {{IW{1'b0}}, col};
	assign ia_x   = {3'b000, idx_a};
	assign ib_x   = {3'b000, idx_b};
	assign row_ok = 32'(row) < MAX_CELLS;
	assign col_ok = 32'(col) < MAX_CELLS;

	// load port
	always_ff @(posedge clk) begin
		if (load_en && !operation && row_ok) begin
			sig_q[row_x[IW-1:0]] <= cross_section;
			vol_q[row_x[IW-1:0]] <= cell_volume;
		end
		if (load_en && operation && row_ok && col_ok) begin
			mat_mem[{row_x[IW-1:0], col_x[IW-1:0]}] <= prob_in;
		end
		mat_q <= mat_mem[{idx_a, idx_b}];
	end

	// operand selection
	always_comb begin
		case (cmd.mul_sel)
			MS_PSI: begin
				mul_a = div_res;
				mul_b = esc_q[idx_a];
			end
			MS_PSIG: begin
				mul_a = psi_q[idx_b];
				mul_b = {1'b0, sig_q[idx_b]};
			end
			MS_ALB: begin
				mul_a = sat_sum(ONE - acc_q);
				mul_b = VAL_W'(albedo);
			end
			MS_T: begin
				mul_a = esc_q[idx_a];
				mul_b = psi_q[idx_b];
			end
			MS_COEF: begin
				mul_a = mul_res;
				mul_b = fac_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		case (cmd.div_sel)
			DS_RAT: begin
				div_a = {2'b00, vol_q[idx_a], 2'b00};
				div_b = {1'b0, surface_area};
			end
			DS_FAC: begin
				div_a = DIVA_W'(albedo);
				div_b = sat_sum(ONE - {{(SUM_W-VAL_W){mul_res[VAL_W-1]}}, mul_res});
			end
			DS_RED: begin
				div_a = {{(DIVA_W-VAL_W){mat_q[VAL_W-1]}}, mat_q};
				div_b = {1'b0, sig_q[idx_b]};
			end
			default: begin
				div_a = '0;
				div_b = '0;
			end
		endcase
	end

	wbc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.res   (mul_res),
		.done  (mul_done)
	);

	wbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.a     (div_a),
		.b     (div_b),
		.res   (div_res),
		.dz    (div_dz),
		.done  (div_done)
	);

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;

	// working values
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add_mat) begin
			acc_q <= acc_q + {{(SUM_W-VAL_W){mat_q[VAL_W-1]}}, mat_q};
		end else if (cmd.acc_add_mul) begin
			acc_q <= acc_q + {{(SUM_W-VAL_W){mul_res[VAL_W-1]}}, mul_res};
		end
		if (cmd.esc_wr) begin
			esc_q[idx_a] <= sat_sum(ONE - acc_q);
		end
		if (cmd.psi_wr) begin
			psi_q[idx_a] <= mul_res;
		end
		if (cmd.fac_wr) begin
			fac_q <= div_res;
		end
		if (cmd.emit) begin
			orow_q  <= ia_x[2:0];
			ocol_q  <= ib_x[2:0];
			oval_q  <= sat_sum({{(SUM_W-VAL_W){div_res[VAL_W-1]}}, div_res}
				+ {{(SUM_W-VAL_W){mul_res[VAL_W-1]}}, mul_res});
			ostat_q <= gerr_q | div_dz;
			olast_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gerr_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.gerr_clr) begin
				gerr_q <= 1'b0;
			end else if (cmd.gerr_upd) begin
				gerr_q <= gerr_q | div_dz;
			end
		end
	end

	assign result_valid = valid_q;
	assign out_row      = orow_q;
	assign out_col      = ocol_q;
	assign prob_out     = oval_q;
	assign status       = ostat_q;
	assign last_out     = olast_q;

endmodule

FILE: design/wbc_ctrl.sv
// ----------------------------------------------------------------------------
// wbc_ctrl
// Sequencer: walks the row sums, escape and surface terms, the albedo
// factor and then every reduced element, driving the datapath.
// ----------------------------------------------------------------------------
module wbc_ctrl #(
	parameter int MAX_CELLS = 8,
	parameter int IW        = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [wbc_pkg::CNT_W-1:0] cell_count,
	input  wbc_pkg::sts_t             sts,
	output wbc_pkg::cmd_t             cmd,
	output logic [IW-1:0]             idx_a,
	output logic [IW-1:0]             idx_b,
	output logic                      busy
);
	import wbc_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SUM_RD  = 4'd1;
	localparam logic [3:0] ST_SUM_ADD = 4'd2;
	localparam logic [3:0] ST_ESC     = 4'd3;
	localparam logic [3:0] ST_RAT_WT  = 4'd4;
	localparam logic [3:0] ST_PSI_WT  = 4'd5;
	localparam logic [3:0] ST_PS_GO   = 4'd6;
	localparam logic [3:0] ST_PS_WT   = 4'd7;
	localparam logic [3:0] ST_ALB_GO  = 4'd8;
	localparam logic [3:0] ST_ALB_WT  = 4'd9;
	localparam logic [3:0] ST_FAC_WT  = 4'd10;
	localparam logic [3:0] ST_EL_RD   = 4'd11;
	localparam logic [3:0] ST_EL_DIV  = 4'd12;
	localparam logic [3:0] ST_EL_DWT  = 4'd13;
	localparam logic [3:0] ST_EL_M1   = 4'd14;
	localparam logic [3:0] ST_EL_M2   = 4'd15;

	logic [3:0]    state_q, state_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d;
	logic [IW-1:0] nm1;
	logic          i_end, j_end;

	always_comb begin
		if (cell_count == '0) begin
			nm1 = '0;
		end else if (32'(cell_count) > MAX_CELLS) begin
			nm1 = IW'(MAX_CELLS - 1);
		end else begin
			nm1 = IW'(cell_count - 1'b1);
		end
	end

	assign i_end = (i_q == nm1);
	assign j_end = (j_q == nm1);

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (go) begin
					cmd.gerr_clr = 1'b1;
					cmd.acc_clr  = 1'b1;
					i_d          = '0;
					j_d          = '0;
					state_d      = ST_SUM_RD;
				end
			end
			ST_SUM_RD: begin
				state_d = ST_SUM_ADD;
			end
			ST_SUM_ADD: begin
				cmd.acc_add_mat = 1'b1;
				if (j_end) begin
					state_d = ST_ESC;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = ST_SUM_RD;
				end
			end
			ST_ESC: begin
				cmd.esc_wr    = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_RAT;
				state_d       = ST_RAT_WT;
			end
			ST_RAT_WT: begin
				if (sts.div_done) begin
					cmd.gerr_upd  = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_PSI;
					state_d       = ST_PSI_WT;
				end
			end
			ST_PSI_WT: begin
				if (sts.mul_done) begin
					cmd.psi_wr  = 1'b1;
					cmd.acc_clr = 1'b1;
					j_d         = '0;
					if (i_end) begin
						state_d = ST_PS_GO;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_SUM_RD;
					end
				end
			end
			ST_PS_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_PSIG;
				state_d       = ST_PS_WT;
			end
			ST_PS_WT: begin
				if (sts.mul_done) begin
					cmd.acc_add_mul = 1'b1;
					if (j_end) begin
						state_d = ST_ALB_GO;
					end else begin
						j_d     = j_q + 1'b1;
						state_d = ST_PS_GO;
					end
				end
			end
			ST_ALB_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MS_ALB;
				state_d       = ST_ALB_WT;
			end
			ST_ALB_WT: begin
				if (sts.mul_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_FAC;
					state_d       = ST_FAC_WT;
				end
			end
			ST_FAC_WT: begin
				if (sts.div_done) begin
					cmd.fac_wr   = 1'b1;
					cmd.gerr_upd = 1'b1;
					i_d          = '0;
					j_d          = '0;
					state_d      = ST_EL_RD;
				end
			end
			ST_EL_RD: begin
				state_d = ST_EL_DIV;
			end
			ST_EL_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DS_RED;
				state_d       = ST_EL_DWT;
			end
			ST_EL_DWT: begin
				cmd.div_sel = DS_RED;
				if (sts.div_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_T;
					state_d       = ST_EL_M1;
				end
			end
			ST_EL_M1: begin
				if (sts.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MS_COEF;
					state_d       = ST_EL_M2;
				end
			end
			ST_EL_M2: begin
				if (sts.mul_done) begin
					cmd.emit = 1'b1;
					cmd.last = i_end && j_end;
					if (j_end) begin
						j_d = '0;
						if (i_end) begin
							state_d = ST_IDLE;
						end else begin
							i_d     = i_q + 1'b1;
							state_d = ST_EL_RD;
						end
					end else begin
						j_d     = j_q + 1'b1;
						state_d = ST_EL_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	assign idx_a = i_q;
	assign idx_b = j_q;
	assign busy  = (state_q != ST_IDLE);

`ifndef SYNTH
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_start && cmd.div_start))
		else $error("multiplier and divider started together");
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.mul_done)
		else $error("element emitted before its product");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("sequencer kept running after the last element");
	a_go_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && go) |=> (state_q == ST_SUM_RD && i_q == '0 && j_q == '0))
		else $error("computation did not start from the first cell");
`endif

endmodule

FILE: design/white_boundary_cp_correction_core.sv
// ----------------------------------------------------------------------------
// white_boundary_cp_correction_core
// White-boundary collision-probability correction for one energy group.
// ----------------------------------------------------------------------------
// Usage:
//  - Configure surface_area, albedo and cell_count over the APB port while
//    idle (byte addresses 0, 8, 16; 64-bit data, pready always high).
//  - Feed load transactions with start; one is accepted per cycle whenever
//    busy is low. operation 0 writes a cell's cross section and volume,
//    operation 1 writes matrix element (row, col). Drop indices not below
//    MAX_CELLS. last_in starts the computation after its own load; busy
//    stays high until the whole matrix has been emitted.
//  - Results come out in row-major order, one per result_valid pulse, with
//    status set when a zero divisor saturated the element or an earlier setup
//    division. The receiver cannot stall; each result_valid pulse lasts one cycle only.
// Timing: the walk is paced by the shared restoring divider (NW quotient
//  bits, NW = 51 + FRAC_BITS) and the four-slice multiplier. With n cells
//  the setup phases run first, then each of the n*n elements in turn;
//  result_valid rises the cycle after an element completes.
// Reset: configuration returns to surface 1.0, albedo 1.0, eight cells; the
//  sequencer goes idle. Cell and matrix stores keep no reset value.
// ----------------------------------------------------------------------------
module white_boundary_cp_correction_core #(
	parameter int MAX_CELLS = 8,
	parameter int FRAC_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wbc_pkg::PADDR_W-1:0] paddr,
	input  logic [wbc_pkg::PDATA_W-1:0] pwdata,
	output logic [wbc_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [2:0]                  row,
	input  logic [2:0]                  col,
	input  logic [wbc_pkg::VAL_W-1:0]   prob_in,
	input  logic [wbc_pkg::MAG_W-1:0]   cross_section,
	input  logic [wbc_pkg::MAG_W-1:0]   cell_volume,
	input  logic                        last_in,
	output logic                        result_valid,
	output logic [2:0]                  out_row,
	output logic [2:0]                  out_col,
	output logic [wbc_pkg::VAL_W-1:0]   prob_out,
	output logic                        status,
	output logic                        last_out
);
	import wbc_pkg::*;

	// cell index width; one bit minimum so a single cell still has an index
	localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	logic [SA_W-1:0]  surface_q;
	logic [ALB_W-1:0] albedo_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic [1:0]       reg_idx;
	logic             accept;
	logic             ctrl_busy;
	cmd_t             cmd;
	sts_t             sts;
	logic [IW-1:0]    idx_a, idx_b;

	// Register file: write on the access phase of an APB write transaction.
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_q <= SA_W'(64'd1 << FRAC_BITS);
			albedo_q  <= ALB_W'(64'd1 << FRAC_BITS);
			count_q   <= CNT_W'(8);
		end else if (wr_en) begin
			case (reg_idx)
				REG_SURFACE: surface_q <= pwdata[SA_W-1:0];
				REG_ALBEDO:  albedo_q  <= pwdata[ALB_W-1:0];
				REG_COUNT:   count_q   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SURFACE: prdata = PDATA_W'(surface_q);
			REG_ALBEDO:  prdata = PDATA_W'(albedo_q);
			REG_COUNT:   prdata = PDATA_W'(count_q);
			default:     prdata = '0;
		endcase
	end

	// A load transaction is taken whenever the sequencer is idle.
	assign accept = start && !ctrl_busy;
	assign busy   = ctrl_busy;

	wbc_ctrl #(
		.MAX_CELLS(MAX_CELLS),
		.IW       (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (accept && last_in),
		.cell_count(count_q),
		.sts       (sts),
		.cmd       (cmd),
		.idx_a     (idx_a),
		.idx_b     (idx_b),
		.busy      (ctrl_busy)
	);

	wbc_dp #(
		.MAX_CELLS(MAX_CELLS),
		.FRAC_BITS(FRAC_BITS),
		.IW       (IW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.idx_a        (idx_a),
		.idx_b        (idx_b),
		.load_en      (accept),
		.operation    (operation),
		.row          (row),
		.col          (col),
		.prob_in      (prob_in),
		.cross_section(cross_section),
		.cell_volume  (cell_volume),
		.surface_area (surface_q),
		.albedo       (albedo_q),
		.result_valid (result_valid),
		.out_row      (out_row),
		.out_col      (out_col),
		.prob_out     (prob_out),
		.status       (status),
		.last_out     (last_out)
	);

endmodule

FILE: dv/tb_white_boundary_cp_correction_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_white_boundary_cp_correction_core
// Loads cell data and collision probability matrices, triggers the white
// boundary correction and checks every emitted element against a predictor
// of the reduced matrix, over several register settings and idling phases.
// ----------------------------------------------------------------------------
module tb_white_boundary_cp_correction_core;
	import wbc_pkg::*;

	localparam int NCELL = 8;
	localparam int FRAC = 24;
	localparam longint ONE_Q = 64'sd1 << FRAC;
	localparam longint POS_LIM = 64'sh7FFF_FFFF_FFFF;
	localparam longint NEG_LIM = -64'sh8000_0000_0000;
	localparam bit OP_CELL = 1'b0;
	localparam bit OP_ELEM = 1'b1;

	typedef struct {
		logic [2:0]       r;
		logic [2:0]       c;
		logic [VAL_W-1:0] v;
		logic             st;
		logic             lst;
	} elem_t;

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	logic                start, busy;
	logic                operation;
	logic [2:0]          row, col;
	logic [VAL_W-1:0]    prob_in;
	logic [MAG_W-1:0]    cross_section, cell_volume;
	logic                last_in;
	logic                result_valid;
	logic [2:0]          out_row, out_col;
	logic [VAL_W-1:0]    prob_out;
	logic                status, last_out;

	// predictor state: register copies and cell/matrix stores
	longint  surf_cfg, alb_cfg;
	int      count_cfg;
	longint  sig_mem[NCELL];
	longint  vol_mem[NCELL];
	longint  mat_mem[NCELL][NCELL];
	longint  esc_mem[NCELL];
	longint  psi_mem[NCELL];

	elem_t   pending_elems[$];
	int      err_count;
	int      idle_pct;

	white_boundary_cp_correction_core dut (.*);

	// 10 ns clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ------------------------------------------------------------------
	// fixed-point helpers of the predictor
	// ------------------------------------------------------------------
	function automatic longint clamp_sum(input longint v);
		if (v > POS_LIM) return POS_LIM;
		if (v < NEG_LIM) return NEG_LIM;
		return v;
	endfunction

	function automatic logic [127:0] abs_wide(input longint v);
		logic [127:0] m;
		m = {{64{v[63]}}, v};
		return v < 0 ? -m : m;
	endfunction

	// attach the sign to a magnitude and clamp to the 48-bit range
	function automatic longint apply_sign(input bit neg, input logic [127:0] m);
		if (neg) return (m > 128'h8000_0000_0000) ? NEG_LIM : -longint'(m[63:0]);
		return (m > 128'h7FFF_FFFF_FFFF) ? POS_LIM : longint'(m[63:0]);
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		logic [127:0] p;
		p = abs_wide(a) * abs_wide(b);
		return apply_sign((a < 0) != (b < 0), p >> FRAC);
	endfunction

	function automatic longint fx_div(input longint a, input longint b, inout bit zdiv);
		logic [127:0] q;
		if (b == 0) begin
			zdiv = 1'b1;
			return a < 0 ? NEG_LIM : POS_LIM;
		end
		q = (abs_wide(a) << FRAC) / abs_wide(b);
		return apply_sign((a < 0) != (b < 0), q);
	endfunction

	// compute escape terms, surface factor and queue the reduced matrix
	task automatic correct_matrix();
		int     n;
		longint acc, pss, den, fac, red, coef;
		bit     gerr, e;
		elem_t  el;
		n = count_cfg < 1 ? 1 : (count_cfg > NCELL ? NCELL : count_cfg);
		gerr = 1'b0;
		for (int i = 0; i < n; i++) begin
			acc = 0;
			for (int j = 0; j < n; j++) acc += mat_mem[i][j];
			esc_mem[i] = clamp_sum(ONE_Q - acc);
			psi_mem[i] = fx_mul(fx_div(4 * vol_mem[i], surf_cfg, gerr), esc_mem[i]);
		end
		acc = 0;
		for (int i = 0; i < n; i++) acc += fx_mul(psi_mem[i], sig_mem[i]);
		pss = clamp_sum(ONE_Q - acc);
		den = clamp_sum(ONE_Q - fx_mul(pss, alb_cfg));
		fac = fx_div(alb_cfg, den, gerr);
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				e = gerr;
				red = fx_div(mat_mem[i][j], sig_mem[j], e);
				coef = fx_mul(fx_mul(esc_mem[i], psi_mem[j]), fac);
				el.r = i[2:0];
				el.c = j[2:0];
				el.v = VAL_W'(clamp_sum(red + coef));
				el.st = e;
				el.lst = (i == n - 1) && (j == n - 1);
				pending_elems.push_back(el);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------
	// drive one load transaction, wait for acceptance, then predict
	task automatic send_load(input bit op, input logic [2:0] r, input logic [2:0] c,
			input logic [VAL_W-1:0] p, input logic [MAG_W-1:0] xs,
			input logic [MAG_W-1:0] vl, input bit lst);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		operation = op;
		row = r;
		col = c;
		prob_in = p;
		cross_section = xs;
		cell_volume = vl;
		last_in = lst;
		do @(posedge clk); while (busy);
		if (op == OP_CELL) begin
			sig_mem[r] = longint'(xs);
			vol_mem[r] = longint'(vl);
		end else begin
			mat_mem[r][c] = longint'($signed(p));
		end
		if (lst) correct_matrix();
	endtask

	// hold off until the block is drained and idle
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		do @(posedge clk); while (busy || pending_elems.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = PADDR_W'(idx) << 3;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_SURFACE: surf_cfg = longint'(value[SA_W-1:0]);
			REG_ALBEDO:  alb_cfg = longint'(value[ALB_W-1:0]);
			REG_COUNT:   count_cfg = int'(value[CNT_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [63:0] sa, input logic [63:0] al, input int n);
		wait_drained();
		write_reg(REG_SURFACE, sa);
		write_reg(REG_ALBEDO, al);
		write_reg(REG_COUNT, 64'(n));
	endtask

	// ------------------------------------------------------------------
	// random content
	// ------------------------------------------------------------------
	function automatic logic [VAL_W-1:0] rand_prob();
		case ($urandom_range(4))
			0: return VAL_W'({$urandom, $urandom});
			1: return VAL_W'($urandom_range(32'h0100_0000));
			2: return -VAL_W'($urandom_range(32'h0040_0000));
			3: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
			default: return VAL_W'($urandom_range(32'h0020_0000));
		endcase
	endfunction

	function automatic logic [MAG_W-1:0] rand_mag();
		case ($urandom_range(5))
			0: return '0;
			1: return MAG_W'({$urandom, $urandom});
			2: return '1;
			default: return MAG_W'($urandom_range(32'h0400_0000, 32'h0008_0000));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		err_count++;
	endtask

	always @(posedge clk) begin
		elem_t ex;
		if (arst_n && result_valid) begin
			if (pending_elems.size() == 0) begin
				report_mismatch($sformatf("unexpected element (%0d,%0d)", out_row, out_col));
			end else begin
				ex = pending_elems.pop_front();
				if (out_row !== ex.r || out_col !== ex.c || prob_out !== ex.v ||
						status !== ex.st || last_out !== ex.lst)
					report_mismatch($sformatf(
						"got (%0d,%0d) %h st%0b l%0b, want (%0d,%0d) %h st%0b l%0b",
						out_row, out_col, prob_out, status, last_out,
						ex.r, ex.c, ex.v, ex.st, ex.lst));
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	// fill every store entry with reset settings, then compute eight cells
	task automatic test_fill_all();
		for (int i = 0; i < NCELL; i++)
			send_load(OP_CELL, i, 0, '0, MAG_W'(32'h0100_0000 + i * 32'h10_0000),
				MAG_W'(32'h0010_0000 * (i + 1)), 1'b0);
		for (int i = 0; i < NCELL; i++)
			for (int j = 0; j < NCELL; j++)
				send_load(OP_ELEM, i, j, VAL_W'(32'h0001_0000 * (i + j + 1)),
					'0, '0, (i == NCELL - 1) && (j == NCELL - 1));
	endtask

	// field extremes, zero divisors, last on a cell load
	task automatic test_special_cases();
		set_regs(64'h0400_0000, 64'h0100_0000, 2);
		send_load(OP_ELEM, 0, 0, VAL_MAX, '0, '0, 1'b0);
		send_load(OP_ELEM, 0, 1, VAL_MIN, '0, '0, 1'b0);
		send_load(OP_ELEM, 1, 1, '0, '0, '0, 1'b0);
		send_load(OP_CELL, 0, 7, '1, '1, '1, 1'b0);
		// zero cross section on cell one: its column saturates
		send_load(OP_CELL, 1, 0, '0, '0, MAG_W'(32'h0100_0000), 1'b1);
		// pick a zero cross section and volume so the denominator vanishes
		set_regs(64'h0100_0000, 64'h0100_0000, 1);
		send_load(OP_CELL, 0, 0, '0, '0, '0, 1'b0);
		send_load(OP_ELEM, 0, 0, '0, '0, '0, 1'b1);
		// zero surface area
		set_regs(64'h0, 64'h0080_0000, 1);
		send_load(OP_CELL, 0, 0, '0, MAG_W'(32'h0100_0000), MAG_W'(32'h0100_0000), 1'b1);
		// count zero taken as one, albedo zero, full surface
		set_regs(64'h7FFF_FFFF_FFFF, 64'h0, 0);
		send_load(OP_ELEM, 0, 0, VAL_W'(32'h0080_0000), '0, '0, 1'b1);
		// count above range taken as eight, albedo above one
		set_regs(64'h0200_0000, 64'h1FF_FFFF, 15);
		send_load(OP_ELEM, 7, 7, rand_prob(), '0, '0, 1'b1);
		set_regs(64'h0100_0000, 64'h0100_0000, 3);
		send_load(OP_CELL, 2, 5, rand_prob(), MAG_W'(32'h0100_0000),
			MAG_W'(32'h0020_0000), 1'b1);
	endtask

	// well-formed load sequences closed by last_in, plus some loose loads
	task automatic test_random_phase(input int pct, input int n, input int items);
		int sent, k, lim;
		bit op;
		idle_pct = 0;
		set_regs(64'(($urandom_range(3) == 0) ? {$urandom, $urandom} & 47'h7FFF_FFFF_FFFF
			: 64'($urandom_range(32'h0800_0000, 32'h0040_0000))),
			64'($urandom_range(32'h0100_0000)), n);
		idle_pct = pct;
		lim = (n < 1) ? 1 : (n > NCELL ? NCELL : n);
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(99) < 85) begin
				k = $urandom_range(2 * lim + 1);
				for (int m = 0; m < k; m++) begin
					op = $urandom_range(1);
					send_load(op, $urandom_range(lim - 1), $urandom_range(lim - 1),
						rand_prob(), rand_mag(), rand_mag(), 1'b0);
				end
				op = $urandom_range(1);
				send_load(op, $urandom_range(7), $urandom_range(7), rand_prob(),
					rand_mag(), rand_mag(), 1'b1);
				sent += k + 1;
			end else begin
				send_load($urandom_range(1), $urandom_range(7), $urandom_range(7),
					rand_prob(), rand_mag(), rand_mag(), $urandom_range(9) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		err_count = 0;
		idle_pct = 0;
		surf_cfg = ONE_Q;
		alb_cfg = ONE_Q;
		count_cfg = 8;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		operation = OP_CELL;
		row = '0;
		col = '0;
		prob_in = '0;
		cross_section = '0;
		cell_volume = '0;
		last_in = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_all();
		test_special_cases();
		test_random_phase(0, 2, 50);
		test_random_phase(46, 3, 50);
		test_random_phase(0, 1, 40);
		test_random_phase(8, 4, 60);
		test_random_phase(46, 2, 50);
		test_random_phase(0, 5, 50);
		test_random_phase(8, 8, 40);
		test_random_phase(46, 6, 36);

		wait_drained();
		repeat (100) @(posedge clk);
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// hard stop in case the block hangs
	initial begin
		#200_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
